[rtl/core/plcm_pkg.sv]
package plcm_pkg;

    localparam int unsigned MAX_POINTS = 8;
    localparam int unsigned LVL_W    = 8;
    localparam int unsigned CHAN_N   = 3;
    localparam int unsigned POINT_W  = 32;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned PROD_W   = 16;
    localparam int unsigned NUM_W    = 17;
    localparam int unsigned DVS_W    = 9;
    localparam int unsigned DIV_STEPS = 4;

    // register indexes on the configuration port
    localparam logic [INDEX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [INDEX_W-1:0] REG_POINTS_FIRST = 3'd1;
    localparam logic [INDEX_W-1:0] REG_POINTS_LAST  = 3'd4;

    typedef logic [CHAN_N-1:0][LVL_W-1:0] t_color;

    // one item inside the divider pipeline
    typedef struct packed {
        logic                          direct;
        logic [DVS_W-1:0]              dvs;
        logic [CHAN_N-1:0][NUM_W-1:0]  rem;
        t_color                        quo;
    } t_div_item;

endpackage

[rtl/core/plcm_div_stage.sv]
module plcm_div_stage #(
    parameter int unsigned HI_BIT = 7
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  plcm_pkg::t_div_item  i_item,
    output plcm_pkg::t_div_item  o_item
);
    import plcm_pkg::*;

    t_div_item r_item;
    t_div_item n_item;

    // two restoring quotient bits per stage
    always_comb begin
        logic [NUM_W:0] trial;
        n_item = i_item;
        trial  = '0;
        if (!i_item.direct) begin
            for (int k = 0; k < CHAN_N; k++) begin
                for (int j = 0; j < 2; j++) begin
                    trial = {1'b0, n_item.rem[k]}
                          - ((NUM_W+1)'(n_item.dvs) << (HI_BIT - j));
                    if (!trial[NUM_W]) begin
                        n_item.rem[k] = trial[NUM_W-1:0];
                        n_item.quo[k][HI_BIT - j] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

[rtl/core/piecewise_linear_colormap_top.sv]
// Gray to RGB color lookup by piecewise linear interpolation between up to
// MAX_POINTS control points (gray, red, green, blue bytes) set through the
// configuration port. One pixel per clock is taken unless the output is held and
// all stages are full, and one RGB result is given per pixel through these stages:
// one stage compares the pixel against all segment ends, one picks the segment,
// one multiplies, one forms the rounded numerator, and a four-stage divider
// retires two quotient bits per stage. Each stage moves independently, so
// bubbles collapse and input keeps flowing while a result waits until all eight
// stages are full. Configuration writes are taken in any cycle out of reset but
// must only be issued while the pipeline is empty.
module piecewise_linear_colormap_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [plcm_pkg::INDEX_W-1:0]   i_cfg_index,
    input  logic [plcm_pkg::WORD_W-1:0]    i_cfg_data,
    // pixel in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // gray_level[7:0]
    // color out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);
    import plcm_pkg::*;

    localparam int unsigned WORD_N = (MAX_POINTS + 1) / 2;
    localparam int unsigned PT_N   = 2 * WORD_N;
    localparam int unsigned SEG_N  = MAX_POINTS - 1;
    localparam int unsigned SEL_W  = $clog2(MAX_POINTS);
    localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int unsigned STG_N  = 4 + DIV_STEPS;

    // configuration
    logic [COUNT_W-1:0]   r_count;
    logic [POINT_W-1:0]   r_points [PT_N];
    logic [CNT_W-1:0]     n_eff;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(2);
            for (int p = 0; p < PT_N; p++) begin
                r_points[p] <= (p == 1) ? {POINT_W{1'b1}} : {POINT_W{1'b0}};
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_POINT_COUNT) begin
                r_count <= i_cfg_data[COUNT_W-1:0];
            end else if (i_cfg_index >= REG_POINTS_FIRST && i_cfg_index <= REG_POINTS_LAST) begin
                for (int w = 0; w < WORD_N; w++) begin
                    if (int'(i_cfg_index - REG_POINTS_FIRST) == w) begin
                        r_points[2*w]   <= i_cfg_data[POINT_W-1:0];
                        r_points[2*w+1] <= i_cfg_data[WORD_W-1:POINT_W];
                    end
                end
            end
        end
    end

    always_comb begin
        priority if (r_count < COUNT_W'(2)) begin
            n_eff = CNT_W'(2);
        end else if (int'(r_count) > int'(MAX_POINTS)) begin
            n_eff = CNT_W'(MAX_POINTS);
        end else begin
            n_eff = CNT_W'(r_count);
        end
    end

    // per-stage flow control
    logic [STG_N-1:0] r_vld;
    logic [STG_N-1:0] rdy;

    always_comb begin
        rdy[STG_N-1] = !r_vld[STG_N-1] || m_axis_tready;
        for (int k = STG_N - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STG_N; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = rdy[0] && i_rst_n;

    // stage 1: compare against every segment end
    logic [7:0]       r_s1_gray;
    logic [SEG_N-1:0] r_s1_hit;
    logic             r_s1_below;
    logic [SEG_N-1:0] n_s1_hit;

    always_comb begin
        for (int i = 0; i < SEG_N; i++) begin
            n_s1_hit[i] = (int'(n_eff) > i + 1) && (s_axis_tdata <= r_points[i+1][7:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s1_gray  <= s_axis_tdata;
            r_s1_hit   <= n_s1_hit;
            r_s1_below <= s_axis_tdata < r_points[0][7:0];
        end
    end

    // stage 2: pick the first qualifying segment and classify
    logic [2*POINT_W-1:0] seg_pair [SEG_N];
    logic [2*POINT_W-1:0] pair;
    logic [SEL_W-1:0]     sel;
    logic [7:0]           g0;
    logic [7:0]           g1;
    t_color               col_lo;
    t_color               col_hi;
    logic                 n_s2_direct;
    t_color               n_s2_color;

    logic                 r_s2_direct;
    t_color               r_s2_color;
    t_color               r_s2_c0;
    t_color               r_s2_c1;
    logic [7:0]           r_s2_w;
    logic [7:0]           r_s2_t;
    logic [7:0]           r_s2_u;

    always_comb begin
        for (int i = 0; i < SEG_N; i++) begin
            seg_pair[i] = {r_points[i+1], r_points[i]};
        end
        // no hit falls back to the last segment, whose upper point is the last one
        sel = SEL_W'(int'(n_eff) - 2);
        for (int i = SEG_N - 1; i >= 0; i--) begin
            if (r_s1_hit[i]) begin
                sel = SEL_W'(i);
            end
        end
        pair   = seg_pair[sel];
        g0     = pair[7:0];
        g1     = pair[POINT_W+7:POINT_W];
        col_lo = pair[POINT_W-1:8];
        col_hi = pair[2*POINT_W-1:POINT_W+8];

        n_s2_direct = 1'b1;
        priority if (r_s1_below) begin
            n_s2_color = r_points[0][POINT_W-1:8];
        end else if (!(|r_s1_hit)) begin
            n_s2_color = col_hi;
        end else if (g1 == g0) begin
            n_s2_color = col_hi;
        end else if (g1 < g0 || r_s1_gray < g0) begin
            n_s2_color = col_lo;
        end else begin
            n_s2_color  = col_lo;
            n_s2_direct = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s2_direct <= n_s2_direct;
            r_s2_color  <= n_s2_color;
            r_s2_c0     <= col_lo;
            r_s2_c1     <= col_hi;
            r_s2_w      <= g1 - g0;
            r_s2_t      <= r_s1_gray - g0;
            r_s2_u      <= g1 - r_s1_gray;
        end
    end

    // stage 3: weighted products c0*(w-t) and c1*t
    logic                          r_s3_direct;
    t_color                        r_s3_color;
    logic [7:0]                    r_s3_w;
    logic [CHAN_N-1:0][PROD_W-1:0] r_s3_p0;
    logic [CHAN_N-1:0][PROD_W-1:0] r_s3_p1;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s3_direct <= r_s2_direct;
            r_s3_color  <= r_s2_color;
            r_s3_w      <= r_s2_w;
            for (int k = 0; k < CHAN_N; k++) begin
                r_s3_p0[k] <= PROD_W'(r_s2_c0[k]) * PROD_W'(r_s2_u);
                r_s3_p1[k] <= PROD_W'(r_s2_c1[k]) * PROD_W'(r_s2_t);
            end
        end
    end

    // stage 4: rounded numerator 2*num + w over divisor 2*w
    t_div_item div_pipe [DIV_STEPS+1];
    t_div_item r_s4_item;
    t_div_item n_s4_item;

    always_comb begin
        logic [PROD_W-1:0] sum;
        sum = '0;
        n_s4_item.direct = r_s3_direct;
        n_s4_item.dvs    = {r_s3_w, 1'b0};
        n_s4_item.quo    = r_s3_direct ? r_s3_color : '0;
        for (int k = 0; k < CHAN_N; k++) begin
            sum = r_s3_p0[k] + r_s3_p1[k];
            n_s4_item.rem[k] = {sum, 1'b0} + NUM_W'(r_s3_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s4_item <= n_s4_item;
        end
    end

    assign div_pipe[0] = r_s4_item;

    // stages 5 to 8: divider, two quotient bits each
    for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
        plcm_div_stage #(
            .HI_BIT(2 * (DIV_STEPS - d) - 1)
        ) u_div_stage (
            .i_clk  (i_clk),
            .i_en   (rdy[4+d]),
            .i_item (div_pipe[d]),
            .o_item (div_pipe[d+1])
        );
    end

    assign m_axis_tvalid = r_vld[STG_N-1];
    assign m_axis_tdata  = div_pipe[DIV_STEPS].quo;

`ifndef SYNTH
    // an empty first stage always takes a pixel
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> s_axis_tready)
        else $error("input stalled with empty first stage");

    // an input transfer lands in the first stage
    a_input_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted pixel lost at first stage");

    // finished interpolation leaves a remainder below the divisor
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !div_pipe[DIV_STEPS].direct |->
            div_pipe[DIV_STEPS].rem[0] < NUM_W'(div_pipe[DIV_STEPS].dvs) &&
            div_pipe[DIV_STEPS].rem[1] < NUM_W'(div_pipe[DIV_STEPS].dvs) &&
            div_pipe[DIV_STEPS].rem[2] < NUM_W'(div_pipe[DIV_STEPS].dvs))
        else $error("divider remainder not reduced");
`endif

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plcm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [INDEX_W-1:0] REG_UNUSED_LOW  = REG_POINTS_LAST + 1'b1;
    localparam logic [INDEX_W-1:0] REG_UNUSED_HIGH = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [INDEX_W-1:0]  i_cfg_index;
    logic [WORD_W-1:0]   i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // gray_level[7:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;   // red[7:0], green[15:8], blue[23:16]

    // copy of the color table as the block should hold it
    logic [3:0]          table_size;
    logic [WORD_W-1:0]   table_words [4];

    logic [23:0]         expected_colors [$];
    int                  error_count   = 0;
    int                  pixel_count   = 0;
    int                  table_loads   = 0;
    int                  cycle_count   = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    bit                  hold_req      = 1'b0;
    int                  hold_left     = 0;

    piecewise_linear_colormap_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] point_entry(input int p);
        return table_words[p / 2][(p % 2) * 32 +: 32];
    endfunction

    function automatic logic [31:0] pack_point(input logic [7:0] gray, input logic [7:0] red,
                                               input logic [7:0] green, input logic [7:0] blue);
        return {blue, green, red, gray};
    endfunction

    // interpolated color for one gray pixel under the current table
    function automatic logic [23:0] predict_color(input logic [7:0] gray);
        int n;
        int i;
        int k;
        int g0;
        int g1;
        int w;
        int t;
        int c0;
        int c1;
        int num;
        int lvl;
        logic [31:0] p_lo;
        logic [31:0] p_hi;
        logic [23:0] color;
        n = table_size;
        if (n < 2) n = 2;
        if (n > 8) n = 8;
        p_lo = point_entry(0);
        if (gray < p_lo[7:0]) return p_lo[31:8];
        for (i = 0; i + 1 < n; i++) begin
            p_lo = point_entry(i);
            p_hi = point_entry(i + 1);
            g0 = p_lo[7:0];
            g1 = p_hi[7:0];
            if (gray > g1) continue;
            if (g1 == g0) return p_hi[31:8];
            if (g1 < g0 || gray < g0) return p_lo[31:8];
            w = g1 - g0;
            t = gray - g0;
            for (k = 0; k < 3; k++) begin
                c0 = p_lo[8 * (k + 1) +: 8];
                c1 = p_hi[8 * (k + 1) +: 8];
                num = c0 * w + (c1 - c0) * t;
                if (num < 0) num = 0;
                lvl = (2 * num + w) / (2 * w);
                if (lvl > 255) lvl = 255;
                color[8 * k +: 8] = lvl[7:0];
            end
            return color;
        end
        p_lo = point_entry(n - 1);
        return p_lo[31:8];
    endfunction

    function automatic logic [7:0] rand_level();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // mostly uniform, a quarter of the time right at or next to a point
    function automatic logic [7:0] random_gray();
        int g;
        logic [31:0] pt;
        if ($urandom_range(3) != 0) return 8'($urandom_range(255));
        pt = point_entry($urandom_range(7));
        g = pt[7:0];
        g = g + $urandom_range(2) - 1;
        if (g < 0) g = 0;
        if (g > 255) g = 255;
        return g[7:0];
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_colors
        logic [23:0] want;
        string chan_name [3];
        int k;
        chan_name = '{"red_level", "green_level", "blue_level"};
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("result transfer 0x%06h with no pixel outstanding", m_axis_tdata);
                    error_count++;
                end else begin
                    want = expected_colors.pop_front();
                    for (k = 0; k < 3; k++) begin
                        if (m_axis_tdata[8 * k +: 8] !== want[8 * k +: 8]) begin
                            $error("%s mismatch: expected %0d, got %0d", chan_name[k],
                                   want[8 * k +: 8], m_axis_tdata[8 * k +: 8]);
                            error_count++;
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_colors.insert(expected_colors.size(), predict_color(s_axis_tdata));
                pixel_count++;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] gray);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= gray;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_colors.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic write_register(input logic [INDEX_W-1:0] index, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            REG_POINT_COUNT: table_size = data[3:0];
            default: begin
                if (index >= REG_POINTS_FIRST && index <= REG_POINTS_LAST)
                    table_words[index - REG_POINTS_FIRST] = data;
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_table(input logic [3:0] count, input logic [WORD_W-1:0] w0,
                              input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                              input logic [WORD_W-1:0] w3, input bit poke_unused);
        wait_idle();
        if (poke_unused) write_register(REG_UNUSED_LOW, {$urandom, $urandom});
        write_register(REG_POINT_COUNT, {60'($urandom), count});
        write_register(REG_POINTS_FIRST, w0);
        write_register(REG_POINTS_FIRST + 3'd1, w1);
        write_register(REG_POINTS_FIRST + 3'd2, w2);
        write_register(REG_POINTS_LAST, w3);
        if (poke_unused) write_register(REG_UNUSED_HIGH, '1);
        i_cfg_valid <= 1'b0;
        table_loads++;
    endtask

    // mostly sorted tables with random colors, some out-of-range counts and pure noise
    task automatic load_random_table();
        logic [WORD_W-1:0] words [4];
        logic [3:0] count;
        int kind;
        int g;
        int p;
        int pick;
        kind = $urandom_range(9);
        if (kind == 0) begin
            count = 4'($urandom);
            for (p = 0; p < 4; p++) words[p] = {$urandom, $urandom};
        end else begin
            pick = $urandom_range(7);
            if (kind == 1) count = (pick < 2) ? 4'(pick) : 4'(pick + 7);
            else count = 4'($urandom_range(2, 8));
            g = ($urandom_range(3) == 0) ? 0 : $urandom_range(80);
            for (p = 0; p < 8; p++) begin
                words[p / 2][(p % 2) * 32 +: 32] =
                    pack_point(g[7:0], rand_level(), rand_level(), rand_level());
                g = g + (($urandom_range(5) == 0) ? 0 : $urandom_range(1, 70));
                if (g > 255) g = 255;
            end
        end
        load_table(count, words[0], words[1], words[2], words[3], $urandom_range(7) == 0);
    endtask

    task automatic test_reset_table();
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd1);
        send_pixel(8'd127);
        send_pixel(8'd254);
    endtask

    // zero-width first segment, half-up rounding, below first and above last point
    task automatic test_segment_cases();
        load_table(4'd4,
                   {pack_point(8'd50, 8'd200, 8'd100, 8'd50), pack_point(8'd50, 8'd1, 8'd2, 8'd3)},
                   {pack_point(8'd200, 8'd0, 8'd255, 8'd0),
                    pack_point(8'd52, 8'd201, 8'd101, 8'd53)},
                   {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_pixel(8'd0);
        send_pixel(8'd49);
        send_pixel(8'd50);
        send_pixel(8'd51);
        send_pixel(8'd52);
        send_pixel(8'd126);
        send_pixel(8'd200);
        send_pixel(8'd201);
        send_pixel(8'd255);
    endtask

    // count above the maximum uses all eight points
    task automatic test_all_points();
        load_table(4'd15,
                   {pack_point(8'd36, 8'd255, 8'd0, 8'd255), pack_point(8'd0, 8'd0, 8'd255, 8'd0)},
                   {pack_point(8'd109, 8'd255, 8'd0, 8'd255),
                    pack_point(8'd73, 8'd0, 8'd255, 8'd0)},
                   {pack_point(8'd182, 8'd255, 8'd0, 8'd255),
                    pack_point(8'd146, 8'd0, 8'd255, 8'd0)},
                   {pack_point(8'd255, 8'd255, 8'd0, 8'd255),
                    pack_point(8'd219, 8'd0, 8'd255, 8'd0)}, 1'b0);
        send_pixel(8'd18);
        send_pixel(8'd100);
        send_pixel(8'd200);
        send_pixel(8'd255);
    endtask

    // counts below two act as two; unused register indexes are written too
    task automatic test_count_limits();
        load_table(4'd0,
                   {pack_point(8'd255, 8'd0, 8'd0, 8'd0), pack_point(8'd0, 8'd255, 8'd255, 8'd255)},
                   {pack_point(8'd20, 8'd9, 8'd9, 8'd9), pack_point(8'd10, 8'd7, 8'd7, 8'd7)},
                   '1, '1, 1'b1);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd255);
        load_table(4'd1, table_words[0], table_words[1], table_words[2], table_words[3], 1'b0);
        send_pixel(8'd64);
    endtask

    task automatic test_random_traffic(input int pixels, input int send_pct, input int stall_pct);
        int done;
        int burst;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < pixels) begin
            load_random_table();
            burst = $urandom_range(30, 70);
            repeat (burst) send_pixel(random_gray());
            done += burst;
        end
    endtask

    // output held off while pixels keep coming, so the input has to stall
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_random_table();
        hold_req = 1'b1;
        repeat (60) send_pixel(random_gray());
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_POINT_COUNT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        table_size    = 4'd2;
        table_words   = '{64'hFFFF_FFFF_0000_0000, 64'd0, 64'd0, 64'd0};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_table();
        test_segment_cases();
        test_all_points();
        test_count_limits();
        test_random_traffic(360, 0, 0);
        test_random_traffic(360, 81, 0);
        test_random_traffic(360, 0, 81);
        test_random_traffic(360, 19, 19);
        test_backpressure();
        wait_idle();

        $display("%0d pixels checked across %0d color tables", pixel_count, table_loads);
        $display("idle mixes: none, input 81%%, output 81%%, both 19%%, plus a long output stall");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
